// ===== rtl/core/rtch_pkg.sv =====
// ----------------------------------------------------------------------------
// rtch_pkg
// Shared types, constants and the multiply-accumulate program of the
// closest-hit ray/triangle search.
// ----------------------------------------------------------------------------
package rtch_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int MAX_TRIANGLES = 65536;
    localparam int CNT_W         = $clog2(MAX_TRIANGLES);

    localparam int COORD_W  = 32;
    localparam int DIR_W    = 18;
    localparam int EDGE_W   = COORD_W + 1;
    localparam int WIDE_W   = 2 * EDGE_W + 2;
    localparam int NARROW_W = EDGE_W + 1;
    localparam int CHUNK_W  = NARROW_W / 2;
    localparam int PROD_W   = WIDE_W + CHUNK_W + 1;
    localparam int ACC_W    = 104;
    localparam int DIV_W    = ACC_W + 32;
    localparam int QUO_W    = 32;
    localparam int T_W      = 31;
    localparam int UV_W     = 17;
    localparam int IDX_W    = 16;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 3;

    localparam int NUM_UOPS   = 24;
    localparam int UOP_IDX_W  = 5;
    localparam int SEQ_W      = 6;
    localparam int DIV_STEPS  = QUO_W;

    // Exact form of det >= 0.00001 at scale 2^(3F), rounded up.
    localparam logic [ACC_W-1:0] DET_MIN =
        ACC_W'(((128'd1 << (3 * FRAC_BITS)) + 128'd99999) / 128'd100000);

    localparam logic [T_W-1:0]  T_SAT  = {T_W{1'b1}};
    localparam logic [UV_W-1:0] UV_SAT = {UV_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_ORIGIN_Z = 3'd2,
        CFG_DIR_X    = 3'd3,
        CFG_DIR_Y    = 3'd4,
        CFG_DIR_Z    = 3'd5
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_CHECK,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_DIV_SAVE,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    // Wide multiplier operand sources.
    typedef enum logic [3:0] {
        A_E1X, A_E1Y, A_E1Z,
        A_SX,  A_SY,  A_SZ,
        A_NX,  A_NY,  A_NZ,
        A_QX,  A_QY,  A_QZ
    } a_src_t;

    // Narrow multiplier operand sources.
    typedef enum logic [3:0] {
        B_E2X, B_E2Y, B_E2Z,
        B_DX,  B_DY,  B_DZ,
        B_E1X, B_E1Y, B_E1Z,
        B_SX,  B_SY,  B_SZ
    } b_src_t;

    typedef enum logic [3:0] {
        D_NX, D_NY, D_NZ,
        D_QX, D_QY, D_QZ,
        D_DEN, D_UN, D_VN, D_TN
    } dst_t;

    typedef enum logic [1:0] {
        DV_T,
        DV_U,
        DV_V
    } div_sel_t;

    typedef struct packed {
        a_src_t a;
        b_src_t b;
        logic   neg;
        logic   first;
        logic   last;
        dst_t   dst;
    } uop_t;

    typedef struct packed {
        logic     load;
        logic     mac_valid;
        uop_t     uop;
        logic     hi;
        logic     check;
        logic     div_load;
        div_sel_t div_sel;
        logic     div_step;
        logic     div_save;
        logic     update;
        logic     emit;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic final_tri;
        logic out_busy;
    } stat_t;

    function automatic uop_t mk_uop(a_src_t a, b_src_t b, logic neg, logic first,
                                    logic last, dst_t dst);
        uop_t u;
        u.a     = a;
        u.b     = b;
        u.neg   = neg;
        u.first = first;
        u.last  = last;
        u.dst   = dst;
        return u;
    endfunction

    // Program: nrm = e1 x e2, q = s x dir, den = -(dir . nrm),
    // un = e2 . q, vn = -(e1 . q), tn = s . nrm.
    function automatic uop_t uop_at(logic [UOP_IDX_W-1:0] idx);
        uop_t u;
        unique case (idx)
            5'd0:    u = mk_uop(A_E1Y, B_E2Z, 1'b0, 1'b1, 1'b0, D_NX);
            5'd1:    u = mk_uop(A_E1Z, B_E2Y, 1'b1, 1'b0, 1'b1, D_NX);
            5'd2:    u = mk_uop(A_E1Z, B_E2X, 1'b0, 1'b1, 1'b0, D_NY);
            5'd3:    u = mk_uop(A_E1X, B_E2Z, 1'b1, 1'b0, 1'b1, D_NY);
            5'd4:    u = mk_uop(A_E1X, B_E2Y, 1'b0, 1'b1, 1'b0, D_NZ);
            5'd5:    u = mk_uop(A_E1Y, B_E2X, 1'b1, 1'b0, 1'b1, D_NZ);
            5'd6:    u = mk_uop(A_SY,  B_DZ,  1'b0, 1'b1, 1'b0, D_QX);
            5'd7:    u = mk_uop(A_SZ,  B_DY,  1'b1, 1'b0, 1'b1, D_QX);
            5'd8:    u = mk_uop(A_SZ,  B_DX,  1'b0, 1'b1, 1'b0, D_QY);
            5'd9:    u = mk_uop(A_SX,  B_DZ,  1'b1, 1'b0, 1'b1, D_QY);
            5'd10:   u = mk_uop(A_SX,  B_DY,  1'b0, 1'b1, 1'b0, D_QZ);
            5'd11:   u = mk_uop(A_SY,  B_DX,  1'b1, 1'b0, 1'b1, D_QZ);
            5'd12:   u = mk_uop(A_NX,  B_DX,  1'b1, 1'b1, 1'b0, D_DEN);
            5'd13:   u = mk_uop(A_NY,  B_DY,  1'b1, 1'b0, 1'b0, D_DEN);
            5'd14:   u = mk_uop(A_NZ,  B_DZ,  1'b1, 1'b0, 1'b1, D_DEN);
            5'd15:   u = mk_uop(A_QX,  B_E2X, 1'b0, 1'b1, 1'b0, D_UN);
            5'd16:   u = mk_uop(A_QY,  B_E2Y, 1'b0, 1'b0, 1'b0, D_UN);
            5'd17:   u = mk_uop(A_QZ,  B_E2Z, 1'b0, 1'b0, 1'b1, D_UN);
            5'd18:   u = mk_uop(A_QX,  B_E1X, 1'b1, 1'b1, 1'b0, D_VN);
            5'd19:   u = mk_uop(A_QY,  B_E1Y, 1'b1, 1'b0, 1'b0, D_VN);
            5'd20:   u = mk_uop(A_QZ,  B_E1Z, 1'b1, 1'b0, 1'b1, D_VN);
            5'd21:   u = mk_uop(A_NX,  B_SX,  1'b0, 1'b1, 1'b0, D_TN);
            5'd22:   u = mk_uop(A_NY,  B_SY,  1'b0, 1'b0, 1'b0, D_TN);
            5'd23:   u = mk_uop(A_NZ,  B_SZ,  1'b0, 1'b0, 1'b1, D_TN);
            default: u = mk_uop(A_E1X, B_E2X, 1'b0, 1'b0, 1'b0, D_NX);
        endcase
        return u;
    endfunction

endpackage

// ===== rtl/core/rtch_ctrl.sv =====
// ----------------------------------------------------------------------------
// rtch_ctrl
// Sequencer: steps the multiply-accumulate program, the hit check and, on a hit,
// the three shared divisions, then updates the closest hit and, after the final triangle, emits the result.
// ----------------------------------------------------------------------------
module rtch_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  rtch_pkg::stat_t stat,
    output rtch_pkg::cmd_t  cmd
);

    rtch_pkg::state_t               state_reg, state_next;
    logic [rtch_pkg::SEQ_W-1:0]     cnt_reg, cnt_next;
    rtch_pkg::div_sel_t             dsel_reg, dsel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rtch_pkg::ST_IDLE;
            cnt_reg   <= '0;
            dsel_reg  <= rtch_pkg::DV_T;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            dsel_reg  <= dsel_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        dsel_next  = dsel_reg;
        cmd        = '0;
        cmd.uop    = rtch_pkg::uop_at(cnt_reg[rtch_pkg::SEQ_W-1:1]);
        cmd.hi     = cnt_reg[0];
        cmd.div_sel = dsel_reg;
        in_stall   = (state_reg != rtch_pkg::ST_IDLE);

        unique case (state_reg)
            rtch_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = rtch_pkg::ST_MAC;
                end
            end
            rtch_pkg::ST_MAC:
            begin
                cmd.mac_valid = 1'b1;
                if (cnt_reg == rtch_pkg::SEQ_W'(2 * rtch_pkg::NUM_UOPS - 1))
                begin
                    state_next = rtch_pkg::ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            rtch_pkg::ST_DRAIN:
            begin
                state_next = rtch_pkg::ST_CHECK;
            end
            rtch_pkg::ST_CHECK:
            begin
                cmd.check  = 1'b1;
                dsel_next  = rtch_pkg::DV_T;
                state_next = rtch_pkg::ST_DIV_LOAD;
            end
            rtch_pkg::ST_DIV_LOAD:
            begin
                if (stat.hit)
                begin
                    cmd.div_load = 1'b1;
                    cnt_next     = '0;
                    state_next   = rtch_pkg::ST_DIV_RUN;
                end
                else
                begin
                    state_next = rtch_pkg::ST_UPDATE;
                end
            end
            rtch_pkg::ST_DIV_RUN:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == rtch_pkg::SEQ_W'(rtch_pkg::DIV_STEPS - 1))
                begin
                    state_next = rtch_pkg::ST_DIV_SAVE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            rtch_pkg::ST_DIV_SAVE:
            begin
                cmd.div_save = 1'b1;
                if (dsel_reg == rtch_pkg::DV_V)
                begin
                    state_next = rtch_pkg::ST_UPDATE;
                end
                else
                begin
                    dsel_next  = (dsel_reg == rtch_pkg::DV_T) ? rtch_pkg::DV_U
                                                              : rtch_pkg::DV_V;
                    state_next = rtch_pkg::ST_DIV_LOAD;
                end
            end
            rtch_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = stat.final_tri ? rtch_pkg::ST_EMIT : rtch_pkg::ST_IDLE;
            end
            rtch_pkg::ST_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = rtch_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rtch_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/rtch_dpath.sv =====
// ----------------------------------------------------------------------------
// rtch_dpath
// Datapath: ray registers, edge setup, a two-stage multiply-accumulate
// unit, hit test, a restoring divider and the closest-hit and output
// registers.
// ----------------------------------------------------------------------------
module rtch_dpath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [rtch_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rtch_pkg::CFG_W-1:0]           cfg_data,
    input  logic signed [rtch_pkg::COORD_W-1:0]  vertex_a_x,
    input  logic signed [rtch_pkg::COORD_W-1:0]  vertex_a_y,
    input  logic signed [rtch_pkg::COORD_W-1:0]  vertex_a_z,
    input  logic signed [rtch_pkg::COORD_W-1:0]  vertex_b_x,
    input  logic signed [rtch_pkg::COORD_W-1:0]  vertex_b_y,
    input  logic signed [rtch_pkg::COORD_W-1:0]  vertex_b_z,
    input  logic signed [rtch_pkg::COORD_W-1:0]  vertex_c_x,
    input  logic signed [rtch_pkg::COORD_W-1:0]  vertex_c_y,
    input  logic signed [rtch_pkg::COORD_W-1:0]  vertex_c_z,
    input  logic                                 final_triangle,
    input  rtch_pkg::cmd_t                       cmd,
    output rtch_pkg::stat_t                      stat,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 hit_found,
    output logic [rtch_pkg::T_W-1:0]             hit_t,
    output logic [rtch_pkg::UV_W-1:0]            hit_u,
    output logic [rtch_pkg::UV_W-1:0]            hit_v,
    output logic [rtch_pkg::IDX_W-1:0]           hit_index
);

    localparam int EW = rtch_pkg::EDGE_W;
    localparam int WW = rtch_pkg::WIDE_W;
    localparam int NW = rtch_pkg::NARROW_W;
    localparam int AW = rtch_pkg::ACC_W;
    localparam int DW = rtch_pkg::DIV_W;

    function automatic logic signed [EW-1:0] sub33(logic signed [rtch_pkg::COORD_W-1:0] x,
                                                   logic signed [rtch_pkg::COORD_W-1:0] y);
        return {x[rtch_pkg::COORD_W-1], x} - {y[rtch_pkg::COORD_W-1], y};
    endfunction

    // Ray registers
    logic signed [rtch_pkg::COORD_W-1:0] org_reg [0:2];
    logic signed [rtch_pkg::DIR_W-1:0]   dir_reg [0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_reg[0] <= '0;
            org_reg[1] <= '0;
            org_reg[2] <= '0;
            dir_reg[0] <= '0;
            dir_reg[1] <= '0;
            dir_reg[2] <= rtch_pkg::DIR_W'(1 << rtch_pkg::FRAC_BITS);
        end
        else if (cfg_write)
        begin
            priority case (rtch_pkg::cfg_idx_t'(cfg_index))
                rtch_pkg::CFG_ORIGIN_X: org_reg[0] <= cfg_data;
                rtch_pkg::CFG_ORIGIN_Y: org_reg[1] <= cfg_data;
                rtch_pkg::CFG_ORIGIN_Z: org_reg[2] <= cfg_data;
                rtch_pkg::CFG_DIR_X:    dir_reg[0] <= cfg_data[rtch_pkg::DIR_W-1:0];
                rtch_pkg::CFG_DIR_Y:    dir_reg[1] <= cfg_data[rtch_pkg::DIR_W-1:0];
                rtch_pkg::CFG_DIR_Z:    dir_reg[2] <= cfg_data[rtch_pkg::DIR_W-1:0];
                default:                ;
            endcase
        end
    end

    // Edge setup, captured when a triangle is taken.
    logic signed [EW-1:0] e1_reg [0:2];
    logic signed [EW-1:0] e2_reg [0:2];
    logic signed [EW-1:0] s_reg  [0:2];
    logic                 final_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            e1_reg[0] <= sub33(vertex_b_x, vertex_a_x);
            e1_reg[1] <= sub33(vertex_b_y, vertex_a_y);
            e1_reg[2] <= sub33(vertex_b_z, vertex_a_z);
            e2_reg[0] <= sub33(vertex_c_x, vertex_a_x);
            e2_reg[1] <= sub33(vertex_c_y, vertex_a_y);
            e2_reg[2] <= sub33(vertex_c_z, vertex_a_z);
            s_reg[0]  <= sub33(org_reg[0], vertex_a_x);
            s_reg[1]  <= sub33(org_reg[1], vertex_a_y);
            s_reg[2]  <= sub33(org_reg[2], vertex_a_z);
            final_reg <= final_triangle;
        end
    end

    // Operand selection
    logic signed [WW-1:0] nrm_reg [0:2];
    logic signed [WW-1:0] q_reg   [0:2];
    logic signed [WW-1:0] a_op;
    logic signed [NW-1:0] b_op;
    logic signed [rtch_pkg::CHUNK_W:0] b_chunk;

    always_comb
    begin
        unique case (cmd.uop.a)
            rtch_pkg::A_E1X: a_op = {{(WW-EW){e1_reg[0][EW-1]}}, e1_reg[0]};
            rtch_pkg::A_E1Y: a_op = {{(WW-EW){e1_reg[1][EW-1]}}, e1_reg[1]};
            rtch_pkg::A_E1Z: a_op = {{(WW-EW){e1_reg[2][EW-1]}}, e1_reg[2]};
            rtch_pkg::A_SX:  a_op = {{(WW-EW){s_reg[0][EW-1]}}, s_reg[0]};
            rtch_pkg::A_SY:  a_op = {{(WW-EW){s_reg[1][EW-1]}}, s_reg[1]};
            rtch_pkg::A_SZ:  a_op = {{(WW-EW){s_reg[2][EW-1]}}, s_reg[2]};
            rtch_pkg::A_NX:  a_op = nrm_reg[0];
            rtch_pkg::A_NY:  a_op = nrm_reg[1];
            rtch_pkg::A_NZ:  a_op = nrm_reg[2];
            rtch_pkg::A_QX:  a_op = q_reg[0];
            rtch_pkg::A_QY:  a_op = q_reg[1];
            rtch_pkg::A_QZ:  a_op = q_reg[2];
            default:         a_op = '0;
        endcase

        unique case (cmd.uop.b)
            rtch_pkg::B_E2X: b_op = {e2_reg[0][EW-1], e2_reg[0]};
            rtch_pkg::B_E2Y: b_op = {e2_reg[1][EW-1], e2_reg[1]};
            rtch_pkg::B_E2Z: b_op = {e2_reg[2][EW-1], e2_reg[2]};
            rtch_pkg::B_DX:  b_op = {{(NW-rtch_pkg::DIR_W){dir_reg[0][rtch_pkg::DIR_W-1]}},
                                     dir_reg[0]};
            rtch_pkg::B_DY:  b_op = {{(NW-rtch_pkg::DIR_W){dir_reg[1][rtch_pkg::DIR_W-1]}},
                                     dir_reg[1]};
            rtch_pkg::B_DZ:  b_op = {{(NW-rtch_pkg::DIR_W){dir_reg[2][rtch_pkg::DIR_W-1]}},
                                     dir_reg[2]};
            rtch_pkg::B_E1X: b_op = {e1_reg[0][EW-1], e1_reg[0]};
            rtch_pkg::B_E1Y: b_op = {e1_reg[1][EW-1], e1_reg[1]};
            rtch_pkg::B_E1Z: b_op = {e1_reg[2][EW-1], e1_reg[2]};
            rtch_pkg::B_SX:  b_op = {s_reg[0][EW-1], s_reg[0]};
            rtch_pkg::B_SY:  b_op = {s_reg[1][EW-1], s_reg[1]};
            rtch_pkg::B_SZ:  b_op = {s_reg[2][EW-1], s_reg[2]};
            default:         b_op = '0;
        endcase

        // The low half is an unsigned digit, the high half carries the sign.
        if (cmd.hi)
        begin
            b_chunk = {b_op[NW-1], b_op[NW-1:rtch_pkg::CHUNK_W]};
        end
        else
        begin
            b_chunk = {1'b0, b_op[rtch_pkg::CHUNK_W-1:0]};
        end
    end

    // Multiply stage
    logic signed [rtch_pkg::PROD_W-1:0] prod_reg;
    logic                               p1_valid_reg;
    logic                               p1_hi_reg;
    logic                               p1_neg_reg;
    logic                               p1_start_reg;
    logic                               p1_last_reg;
    rtch_pkg::dst_t                     p1_dst_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= cmd.mac_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mac_valid)
        begin
            prod_reg     <= a_op * b_chunk;
            p1_hi_reg    <= cmd.hi;
            p1_neg_reg   <= cmd.uop.neg;
            p1_start_reg <= cmd.uop.first & ~cmd.hi;
            p1_last_reg  <= cmd.uop.last & cmd.hi;
            p1_dst_reg   <= cmd.uop.dst;
        end
    end

    // Accumulate stage
    logic signed [AW-1:0] acc_reg, acc_next;
    logic signed [AW-1:0] prod_ext, term;
    logic signed [AW-1:0] den_reg, un_reg, vn_reg, tn_reg;

    always_comb
    begin
        prod_ext = {{(AW-rtch_pkg::PROD_W){prod_reg[rtch_pkg::PROD_W-1]}}, prod_reg};
        if (p1_hi_reg)
        begin
            prod_ext = prod_ext <<< rtch_pkg::CHUNK_W;
        end
        term     = p1_neg_reg ? -prod_ext : prod_ext;
        acc_next = (p1_start_reg ? '0 : acc_reg) + term;
    end

    always_ff @(posedge clk)
    begin
        if (p1_valid_reg)
        begin
            acc_reg <= acc_next;
            if (p1_last_reg)
            begin
                unique case (p1_dst_reg)
                    rtch_pkg::D_NX:  nrm_reg[0] <= acc_next[WW-1:0];
                    rtch_pkg::D_NY:  nrm_reg[1] <= acc_next[WW-1:0];
                    rtch_pkg::D_NZ:  nrm_reg[2] <= acc_next[WW-1:0];
                    rtch_pkg::D_QX:  q_reg[0]   <= acc_next[WW-1:0];
                    rtch_pkg::D_QY:  q_reg[1]   <= acc_next[WW-1:0];
                    rtch_pkg::D_QZ:  q_reg[2]   <= acc_next[WW-1:0];
                    rtch_pkg::D_DEN: den_reg    <= acc_next;
                    rtch_pkg::D_UN:  un_reg     <= acc_next;
                    rtch_pkg::D_VN:  vn_reg     <= acc_next;
                    rtch_pkg::D_TN:  tn_reg     <= acc_next;
                    default:         ;
                endcase
            end
        end
    end

    // Hit test
    logic           hit_reg;
    logic [AW:0]    uv_sum;
    logic           hit_now;

    always_comb
    begin
        uv_sum  = {1'b0, un_reg} + {1'b0, vn_reg};
        hit_now = !den_reg[AW-1] && (den_reg >= rtch_pkg::DET_MIN)
                  && !tn_reg[AW-1] && !un_reg[AW-1] && !vn_reg[AW-1]
                  && (uv_sum <= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (cmd.check)
        begin
            hit_reg <= hit_now;
        end
    end

    // Restoring divider: one quotient bit per cycle.
    logic [DW-1:0]                  num_reg, dvs_reg;
    logic [rtch_pkg::QUO_W-1:0]     quo_reg;
    logic [AW-1:0]                  div_src;
    logic                           div_ge;
    logic [rtch_pkg::T_W-1:0]       tq_reg;
    logic [rtch_pkg::UV_W-1:0]      uq_reg, vq_reg;
    logic [rtch_pkg::UV_W-1:0]      uv_quo;

    always_comb
    begin
        unique case (cmd.div_sel)
            rtch_pkg::DV_T: div_src = tn_reg;
            rtch_pkg::DV_U: div_src = un_reg;
            rtch_pkg::DV_V: div_src = vn_reg;
            default:        div_src = tn_reg;
        endcase
        div_ge = (num_reg >= dvs_reg);
        uv_quo = (quo_reg >= rtch_pkg::QUO_W'(rtch_pkg::UV_SAT))
                 ? rtch_pkg::UV_SAT : quo_reg[rtch_pkg::UV_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            num_reg <= DW'(div_src) << rtch_pkg::FRAC_BITS;
            dvs_reg <= DW'(den_reg) << (rtch_pkg::QUO_W - 1);
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (div_ge)
            begin
                num_reg <= num_reg - dvs_reg;
            end
            quo_reg <= {quo_reg[rtch_pkg::QUO_W-2:0], div_ge};
            dvs_reg <= dvs_reg >> 1;
        end

        if (cmd.div_save)
        begin
            unique case (cmd.div_sel)
                rtch_pkg::DV_T: tq_reg <= quo_reg[rtch_pkg::QUO_W-1]
                                          ? rtch_pkg::T_SAT : quo_reg[rtch_pkg::T_W-1:0];
                rtch_pkg::DV_U: uq_reg <= uv_quo;
                rtch_pkg::DV_V: vq_reg <= uv_quo;
                default:        ;
            endcase
        end
    end

    // Closest hit, triangle numbering and the output register
    logic [rtch_pkg::QUO_W-1:0]  best_t_reg;
    logic [rtch_pkg::UV_W-1:0]   best_u_reg, best_v_reg;
    logic [rtch_pkg::IDX_W-1:0]  best_idx_reg;
    logic                        any_hit_reg;
    logic [rtch_pkg::CNT_W-1:0]  count_reg;
    logic                        out_valid_reg;
    logic                        out_hit_reg;
    logic [rtch_pkg::T_W-1:0]    out_t_reg;
    logic [rtch_pkg::UV_W-1:0]   out_u_reg, out_v_reg;
    logic [rtch_pkg::IDX_W-1:0]  out_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_t_reg    <= '1;
            best_u_reg    <= '0;
            best_v_reg    <= '0;
            best_idx_reg  <= '0;
            any_hit_reg   <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.update)
            begin
                if (hit_reg && ({1'b0, tq_reg} <= best_t_reg))
                begin
                    best_t_reg   <= {1'b0, tq_reg};
                    best_u_reg   <= uq_reg;
                    best_v_reg   <= vq_reg;
                    best_idx_reg <= rtch_pkg::IDX_W'(count_reg);
                    any_hit_reg  <= 1'b1;
                end
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.emit)
            begin
                best_t_reg   <= '1;
                best_u_reg   <= '0;
                best_v_reg   <= '0;
                best_idx_reg <= '0;
                any_hit_reg  <= 1'b0;
                count_reg    <= '0;
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_hit_reg <= any_hit_reg;
            out_t_reg   <= any_hit_reg ? best_t_reg[rtch_pkg::T_W-1:0] : '0;
            out_u_reg   <= any_hit_reg ? best_u_reg : '0;
            out_v_reg   <= any_hit_reg ? best_v_reg : '0;
            out_idx_reg <= any_hit_reg ? best_idx_reg : '0;
        end
    end

    assign stat.hit       = hit_reg;
    assign stat.final_tri = final_reg;
    assign stat.out_busy  = out_valid_reg & out_stall;

    assign out_valid = out_valid_reg;
    assign hit_found = out_hit_reg;
    assign hit_t     = out_t_reg;
    assign hit_u     = out_u_reg;
    assign hit_v     = out_v_reg;
    assign hit_index = out_idx_reg;

endmodule

// ===== rtl/core/ray_triangle_closest_hit_top.sv =====
// ----------------------------------------------------------------------------
// ray_triangle_closest_hit_top
// Closest-hit search of one ray over a stream of triangles, using the
// back-face-culling Moller-Trumbore test in exact fixed point.
// ----------------------------------------------------------------------------
// Usage: write the ray origin and unit direction through the configuration
// port (index 0..2 origin, 3..5 direction) while the block is idle. Then
// send triangles on the input channel, one transfer per triangle; the
// transfer with final_triangle set closes the mesh. Only that triangle
// produces a transfer on the output channel, carrying the closest hit (or
// hit_found low and zeros), after which the running state is cleared.
// Throughput: one triangle at a time. A miss keeps the input stalled after
// its transfer through the multiply-accumulate program, the hit check and
// the update; a hit keeps it stalled through the three divisions as well.
// The stall is set by the single shared multiply-accumulate unit, which
// runs 24 products in two halves each, and by the one shared restoring
// divider, which divides t, u and v in turn, with a load and a save step
// for each. The result of the final triangle enters the output register
// from the emit state once that register is free, and the block then
// returns to idle to take the next triangle. Reset returns the ray to
// origin zero pointing along +z and clears the running best hit and the
// triangle count. While the receiver stalls, the result holds in the
// output register; a later final triangle waits in the controller until
// that register is free.
// ----------------------------------------------------------------------------
module ray_triangle_closest_hit_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [rtch_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rtch_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [rtch_pkg::COORD_W-1:0]  vertex_a_x,
    input  logic signed [rtch_pkg::COORD_W-1:0]  vertex_a_y,
    input  logic signed [rtch_pkg::COORD_W-1:0]  vertex_a_z,
    input  logic signed [rtch_pkg::COORD_W-1:0]  vertex_b_x,
    input  logic signed [rtch_pkg::COORD_W-1:0]  vertex_b_y,
    input  logic signed [rtch_pkg::COORD_W-1:0]  vertex_b_z,
    input  logic signed [rtch_pkg::COORD_W-1:0]  vertex_c_x,
    input  logic signed [rtch_pkg::COORD_W-1:0]  vertex_c_y,
    input  logic signed [rtch_pkg::COORD_W-1:0]  vertex_c_z,
    input  logic                                 final_triangle,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 hit_found,
    output logic [rtch_pkg::T_W-1:0]             hit_t,
    output logic [rtch_pkg::UV_W-1:0]            hit_u,
    output logic [rtch_pkg::UV_W-1:0]            hit_v,
    output logic [rtch_pkg::IDX_W-1:0]           hit_index
);

    rtch_pkg::cmd_t  cmd;
    rtch_pkg::stat_t stat;

    // The controller owns sequencing; the datapath owns every number.
    rtch_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    rtch_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .vertex_a_x     (vertex_a_x),
        .vertex_a_y     (vertex_a_y),
        .vertex_a_z     (vertex_a_z),
        .vertex_b_x     (vertex_b_x),
        .vertex_b_y     (vertex_b_y),
        .vertex_b_z     (vertex_b_z),
        .vertex_c_x     (vertex_c_x),
        .vertex_c_y     (vertex_c_y),
        .vertex_c_z     (vertex_c_z),
        .final_triangle (final_triangle),
        .cmd            (cmd),
        .stat           (stat),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hit_found      (hit_found),
        .hit_t          (hit_t),
        .hit_u          (hit_u),
        .hit_v          (hit_v),
        .hit_index      (hit_index)
    );

    // A result without a hit carries all zeros.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !hit_found) |->
            (hit_t == '0 && hit_u == '0 && hit_v == '0 && hit_index == '0))
        else $error("miss result carries nonzero fields");

    // Barycentrics of a reported hit lie inside the triangle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && hit_found) |->
            (({1'b0, hit_u} + {1'b0, hit_v}) <=
             (rtch_pkg::UV_W + 1)'(1 << rtch_pkg::FRAC_BITS)))
        else $error("hit u + v exceeds one");

    // No triangle is taken while the arithmetic units are busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mac_valid || cmd.div_step || cmd.emit) |-> in_stall)
        else $error("input taken during computation");

endmodule

// ===== sim/ray_triangle_closest_hit_checker.sv =====
// ----------------------------------------------------------------------------
// ray_triangle_closest_hit_checker
// Watches the configuration port and both channels of the closest-hit block,
// predicts the hit record of every closed mesh in exact wide integers and
// compares it field by field with what the block sends.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ray_triangle_closest_hit_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [rtch_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rtch_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic signed [rtch_pkg::COORD_W-1:0]  vertex_a_x,
    input  logic signed [rtch_pkg::COORD_W-1:0]  vertex_a_y,
    input  logic signed [rtch_pkg::COORD_W-1:0]  vertex_a_z,
    input  logic signed [rtch_pkg::COORD_W-1:0]  vertex_b_x,
    input  logic signed [rtch_pkg::COORD_W-1:0]  vertex_b_y,
    input  logic signed [rtch_pkg::COORD_W-1:0]  vertex_b_z,
    input  logic signed [rtch_pkg::COORD_W-1:0]  vertex_c_x,
    input  logic signed [rtch_pkg::COORD_W-1:0]  vertex_c_y,
    input  logic signed [rtch_pkg::COORD_W-1:0]  vertex_c_z,
    input  logic                                 final_triangle,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic                                 hit_found,
    input  logic [rtch_pkg::T_W-1:0]             hit_t,
    input  logic [rtch_pkg::UV_W-1:0]            hit_u,
    input  logic [rtch_pkg::UV_W-1:0]            hit_v,
    input  logic [rtch_pkg::IDX_W-1:0]           hit_index,
    output int                                   mismatch_count,
    output int                                   pending_hits
);

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic                       found;
        logic [rtch_pkg::T_W-1:0]   t;
        logic [rtch_pkg::UV_W-1:0]  u;
        logic [rtch_pkg::UV_W-1:0]  v;
        logic [rtch_pkg::IDX_W-1:0] index;
    } hit_rec_t;

    // det >= 0.00001 in exact form at scale 2^(3F), rounded up.
    localparam wide_t DET_LIMIT =
        ((128'sd1 <<< (3 * rtch_pkg::FRAC_BITS)) + 128'sd99999) / 128'sd100000;

    hit_rec_t                            closest_hit_q[$];
    logic signed [rtch_pkg::COORD_W-1:0] ray_org[3];
    logic signed [rtch_pkg::DIR_W-1:0]   ray_dir[3];
    logic [31:0]                         best_t;
    logic [rtch_pkg::UV_W-1:0]           best_u;
    logic [rtch_pkg::UV_W-1:0]           best_v;
    logic [rtch_pkg::IDX_W-1:0]          best_index;
    logic                                any_hit;
    logic [rtch_pkg::IDX_W-1:0]          triangle_count;

    assign pending_hits = closest_hit_q.size();

    // floor(num * 2^F / den), saturated to 31 bits.
    function automatic logic [31:0] scaled_ratio(input wide_t num, input wide_t den);
        wide_t q;
        q = (num <<< rtch_pkg::FRAC_BITS) / den;
        if (q > 128'sh7FFF_FFFF)
            return 32'h7FFF_FFFF;
        return q[31:0];
    endfunction

    function automatic void clear_mesh();
        best_t         = '1;
        best_u         = '0;
        best_v         = '0;
        best_index     = '0;
        any_hit        = 1'b0;
        triangle_count = '0;
    endfunction

    always @(posedge clk or negedge rst_n) begin : track
        wide_t       va[3], vb[3], vc[3], e1[3], e2[3], sv[3], dv[3], nv[3], qv[3];
        wide_t       den, un, vn, tn;
        logic [31:0] tq, uq, vq;
        hit_rec_t    rec, got;
        if (!rst_n) begin
            ray_org = '{0, 0, 0};
            ray_dir = '{0, 0, 18'sd65536};
            clear_mesh();
            closest_hit_q.delete();
            mismatch_count = 0;
        end
        else begin
            if (cfg_write) begin
                case (rtch_pkg::cfg_idx_t'(cfg_index))
                    rtch_pkg::CFG_ORIGIN_X: ray_org[0] = cfg_data;
                    rtch_pkg::CFG_ORIGIN_Y: ray_org[1] = cfg_data;
                    rtch_pkg::CFG_ORIGIN_Z: ray_org[2] = cfg_data;
                    rtch_pkg::CFG_DIR_X:    ray_dir[0] = cfg_data[rtch_pkg::DIR_W-1:0];
                    rtch_pkg::CFG_DIR_Y:    ray_dir[1] = cfg_data[rtch_pkg::DIR_W-1:0];
                    rtch_pkg::CFG_DIR_Z:    ray_dir[2] = cfg_data[rtch_pkg::DIR_W-1:0];
                    default:                ;
                endcase
            end

            if (in_valid && !in_stall) begin
                va = '{vertex_a_x, vertex_a_y, vertex_a_z};
                vb = '{vertex_b_x, vertex_b_y, vertex_b_z};
                vc = '{vertex_c_x, vertex_c_y, vertex_c_z};
                for (int i = 0; i < 3; i++) begin
                    dv[i] = ray_dir[i];
                    e1[i] = vb[i] - va[i];
                    e2[i] = vc[i] - va[i];
                    sv[i] = wide_t'(ray_org[i]) - va[i];
                end
                nv[0] = e1[1] * e2[2] - e1[2] * e2[1];
                nv[1] = e1[2] * e2[0] - e1[0] * e2[2];
                nv[2] = e1[0] * e2[1] - e1[1] * e2[0];
                qv[0] = sv[1] * dv[2] - sv[2] * dv[1];
                qv[1] = sv[2] * dv[0] - sv[0] * dv[2];
                qv[2] = sv[0] * dv[1] - sv[1] * dv[0];
                den = -(dv[0] * nv[0] + dv[1] * nv[1] + dv[2] * nv[2]);
                un  =   e2[0] * qv[0] + e2[1] * qv[1] + e2[2] * qv[2];
                vn  = -(e1[0] * qv[0] + e1[1] * qv[1] + e1[2] * qv[2]);
                tn  =   sv[0] * nv[0] + sv[1] * nv[1] + sv[2] * nv[2];

                // Back faces, grazing rays and points outside the triangle
                // all fall out here; a tie on t goes to the later triangle.
                if (den >= DET_LIMIT && tn >= 0 && un >= 0 && vn >= 0 && un + vn <= den) begin
                    tq = scaled_ratio(tn, den);
                    uq = scaled_ratio(un, den);
                    vq = scaled_ratio(vn, den);
                    if (uq > 32'h1FFFF) uq = 32'h1FFFF;
                    if (vq > 32'h1FFFF) vq = 32'h1FFFF;
                    if (tq <= best_t) begin
                        best_t     = tq;
                        best_u     = uq[rtch_pkg::UV_W-1:0];
                        best_v     = vq[rtch_pkg::UV_W-1:0];
                        best_index = triangle_count;
                        any_hit    = 1'b1;
                    end
                end
                triangle_count = triangle_count + 1'b1;

                if (final_triangle) begin
                    rec.found = any_hit;
                    rec.t     = any_hit ? best_t[rtch_pkg::T_W-1:0] : '0;
                    rec.u     = any_hit ? best_u : '0;
                    rec.v     = any_hit ? best_v : '0;
                    rec.index = any_hit ? best_index : '0;
                    closest_hit_q.push_back(rec);
                    clear_mesh();
                end
            end

            if (out_valid && !out_stall) begin
                got = '{hit_found, hit_t, hit_u, hit_v, hit_index};
                if (closest_hit_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: result transfer with no closed mesh pending: found=%0b t=%0h",
                                 got.found, got.t);
                end
                else begin
                    rec = closest_hit_q.pop_front();
                    if (got.found !== rec.found || got.t !== rec.t || got.u !== rec.u ||
                        got.v !== rec.v || got.index !== rec.index) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"ERROR: hit mismatch expected found=%0b t=%0h u=%0h v=%0h idx=%0d",
                                      " got found=%0b t=%0h u=%0h v=%0h idx=%0d"},
                                     rec.found, rec.t, rec.u, rec.v, rec.index,
                                     got.found, got.t, got.u, got.v, got.index);
                    end
                end
            end
        end
    end

endmodule

// ===== sim/ray_triangle_closest_hit_top_tb.sv =====
// ----------------------------------------------------------------------------
// ray_triangle_closest_hit_top_tb
// Drives rays and triangle meshes into the closest-hit block and gives the
// verdict. A directed opening covers hits, back faces, ties, edges, the det
// threshold and t saturation; then random phases change the ray and send
// meshes built mostly from triangles placed on the ray, mixed with noise.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ray_triangle_closest_hit_top_tb;

    typedef logic signed [rtch_pkg::COORD_W-1:0] tri_t [9];

    localparam longint ONE         = 64'sd65536;
    localparam int     RANDOM_TRIS = 650;
    localparam int     CYCLE_LIMIT = 3_000_000;
    // A hit keeps the block busy through all three divisions; give it plenty of room
    // before the ray registers are touched again.
    localparam int     SETTLE      = 300;

    typedef enum logic [1:0] { STALL_NONE, STALL_SCATTER, STALL_LONG } stall_mode_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_write = 1'b0;
    logic [rtch_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [rtch_pkg::CFG_W-1:0]          cfg_data = '0;
    logic                                in_valid = 1'b0;
    logic                                in_stall;
    logic signed [rtch_pkg::COORD_W-1:0] vertex_a_x = '0, vertex_a_y = '0, vertex_a_z = '0;
    logic signed [rtch_pkg::COORD_W-1:0] vertex_b_x = '0, vertex_b_y = '0, vertex_b_z = '0;
    logic signed [rtch_pkg::COORD_W-1:0] vertex_c_x = '0, vertex_c_y = '0, vertex_c_z = '0;
    logic                                final_triangle = 1'b0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic                                hit_found;
    logic [rtch_pkg::T_W-1:0]            hit_t;
    logic [rtch_pkg::UV_W-1:0]           hit_u;
    logic [rtch_pkg::UV_W-1:0]           hit_v;
    logic [rtch_pkg::IDX_W-1:0]          hit_index;
    int                                  mismatch_count;
    int                                  pending_hits;

    // Mirror of the ray, used only to place triangles where the ray goes.
    longint ray_o[3];
    longint ray_d[3];
    tri_t   last_tri;
    int     burst_left = 0;
    int     cycle_count = 0;
    int     stall_tick = 0;
    stall_mode_t stall_mode = STALL_NONE;

    ray_triangle_closest_hit_top dut (.*);

    ray_triangle_closest_hit_checker checker_i (.*);

    always #10 clk = ~clk;

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // The receiver changes its mood periodically: no stalls at all,
    // scattered random stalls, or long blocks of stall.
    always @(posedge clk) begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 200 == 0)
            stall_mode <= stall_mode_t'($urandom_range(0, 2));
        case (stall_mode)
            STALL_NONE:    out_stall <= 1'b0;
            STALL_SCATTER: out_stall <= ($urandom_range(0, 2) == 0);
            default:       out_stall <= (stall_tick % 64) < 40;
        endcase
    end

    // Writes all six ray registers back to back while the block is idle.
    task automatic write_ray(input logic [31:0] ox, input logic [31:0] oy,
                             input logic [31:0] oz, input logic [31:0] dx,
                             input logic [31:0] dy, input logic [31:0] dz);
        logic [31:0] vals[6];
        vals = '{ox, oy, oz, dx, dy, dz};
        cfg_write <= 1'b1;
        for (int i = 0; i < 6; i++) begin
            cfg_index <= rtch_pkg::CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        for (int i = 0; i < 3; i++) begin
            ray_o[i] = longint'($signed(vals[i]));
            ray_d[i] = longint'($signed(vals[3 + i][rtch_pkg::DIR_W-1:0]));
        end
    endtask

    // Drops the input, waits until every closed mesh has reported, then lets
    // the block finish any triangle that is still in flight.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_hits != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // One triangle transfer, followed by the sender's burst and gap pacing.
    task automatic send_tri(input tri_t v, input logic fin);
        in_valid       <= 1'b1;
        vertex_a_x     <= v[0];
        vertex_a_y     <= v[1];
        vertex_a_z     <= v[2];
        vertex_b_x     <= v[3];
        vertex_b_y     <= v[4];
        vertex_b_z     <= v[5];
        vertex_c_x     <= v[6];
        vertex_c_y     <= v[7];
        vertex_c_z     <= v[8];
        final_triangle <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        last_tri = v;
        if (burst_left > 0)
            burst_left--;
        else begin
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(40, 120)
                                              : $urandom_range(1, 30))
                @(posedge clk);
            burst_left = $urandom_range(0, 4) == 0 ? 40 : $urandom_range(0, 10);
        end
    endtask

    function automatic tri_t make_tri(input longint ax, input longint ay, input longint az,
                                      input longint bx, input longint by, input longint bz,
                                      input longint cx, input longint cy, input longint cz);
        tri_t v;
        v = '{ax[31:0], ay[31:0], az[31:0], bx[31:0], by[31:0], bz[31:0],
              cx[31:0], cy[31:0], cz[31:0]};
        return v;
    endfunction

    // Places a front-facing triangle around the point t_units along the ray,
    // so that the ray passes near its center.
    function automatic tri_t tri_on_ray(input int t_units);
        longint p[3], e1[3], e2[3], n[3], tmp, dn;
        tri_t   v;
        for (int i = 0; i < 3; i++) begin
            p[i]  = ray_o[i] + longint'(t_units) * ray_d[i];
            e1[i] = longint'($urandom_range(0, 1 << 19)) - (1 << 18);
            e2[i] = longint'($urandom_range(0, 1 << 19)) - (1 << 18);
        end
        n[0] = e1[1] * e2[2] - e1[2] * e2[1];
        n[1] = e1[2] * e2[0] - e1[0] * e2[2];
        n[2] = e1[0] * e2[1] - e1[1] * e2[0];
        dn = ray_d[0] * n[0] + ray_d[1] * n[1] + ray_d[2] * n[2];
        // The block culls back faces, so turn the winding against the ray.
        if (dn > 0) begin
            for (int i = 0; i < 3; i++) begin
                tmp   = e1[i];
                e1[i] = e2[i];
                e2[i] = tmp;
            end
        end
        for (int i = 0; i < 3; i++) begin
            tmp      = p[i] - ((e1[i] + e2[i]) >>> 2);
            v[i]     = tmp[31:0];
            tmp      = tmp + e1[i];
            v[3 + i] = tmp[31:0];
            tmp      = p[i] - ((e1[i] + e2[i]) >>> 2) + e2[i];
            v[6 + i] = tmp[31:0];
        end
        return v;
    endfunction

    function automatic tri_t noise_tri();
        tri_t v;
        for (int i = 0; i < 9; i++)
            v[i] = ($urandom_range(0, 1) == 0)
                   ? $urandom
                   : rtch_pkg::COORD_W'($urandom_range(0, 1 << 22) - (1 << 21));
        return v;
    endfunction

    // Picks a new ray; the direction is often a proper unit axis, sometimes
    // anything the 18-bit registers can hold, and now and then zero.
    task automatic random_ray();
        logic [31:0] o[3], d[3];
        int          omode, dmode, axis;
        omode = $urandom_range(0, 9);
        dmode = $urandom_range(0, 9);
        axis  = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++) begin
            case (omode)
                0:       o[i] = '0;
                1:       o[i] = $urandom;
                2:       o[i] = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                default: o[i] = $urandom_range(0, 1 << 25) - (1 << 24);
            endcase
            case (dmode)
                0, 1, 2, 3: d[i] = (i == axis) ? ($urandom_range(0, 1) ? 32'd65536 : -32'sd65536)
                                               : 32'd0;
                4, 5, 6:    d[i] = $urandom_range(0, 131072) - 65536;
                7:          d[i] = $urandom_range(0, 1) ? 32'h0001_FFFF : 32'h0002_0000;
                8:          d[i] = $urandom;
                default:    d[i] = '0;
            endcase
        end
        write_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
    endtask

    initial begin : stimulus
        tri_t tri_v;
        int   sent, phase_end, mesh_len, kind;
        logic fin;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset ray: origin zero, looking along +z.
        // A front face at z = 1 hits with u = v = 1/4; its mirror image is a
        // back face; a farther one loses; an exact copy ties and wins.
        send_tri(make_tri(-ONE, -ONE, ONE, -ONE, 3 * ONE, ONE, 3 * ONE, -ONE, ONE), 1'b0);
        send_tri(make_tri(-ONE, -ONE, ONE, 3 * ONE, -ONE, ONE, -ONE, 3 * ONE, ONE), 1'b0);
        send_tri(make_tri(-ONE, -ONE, 5 * ONE, -ONE, 3 * ONE, 5 * ONE, 3 * ONE, -ONE, 5 * ONE),
                 1'b0);
        send_tri(make_tri(-ONE, -ONE, ONE, -ONE, 3 * ONE, ONE, 3 * ONE, -ONE, ONE), 1'b1);
        // A one-triangle mesh that misses, and one behind the origin.
        send_tri(make_tri(5 * ONE, 5 * ONE, ONE, 5 * ONE, 9 * ONE, ONE, 9 * ONE, 5 * ONE, ONE),
                 1'b1);
        send_tri(make_tri(-ONE, -ONE, -2 * ONE, -ONE, 3 * ONE, -2 * ONE, 3 * ONE, -ONE, -2 * ONE),
                 1'b1);
        // Ray through a vertex (u = v = 0) and through the far edge (u + v = 1).
        send_tri(make_tri(0, 0, 2 * ONE, 0, 4 * ONE, 2 * ONE, 4 * ONE, 0, 2 * ONE), 1'b1);
        send_tri(make_tri(-4 * ONE, -4 * ONE, 3 * ONE, -4 * ONE, 4 * ONE, 3 * ONE,
                          4 * ONE, -4 * ONE, 3 * ONE), 1'b1);
        // Tiny triangles just under and just over the det threshold.
        send_tri(make_tri(-100, -100, ONE, -100, 107, ONE, 107, -100, ONE), 1'b1);
        send_tri(make_tri(-100, -100, ONE, -100, 108, ONE, 108, -100, ONE), 1'b1);
        // Coordinate extremes, all at the most negative and most positive value.
        send_tri(make_tri(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                          -64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                          -64'sd2147483648, -64'sd2147483648, -64'sd2147483648), 1'b0);
        send_tri(make_tri(64'sd2147483647, 64'sd2147483647, 64'sd2147483647,
                          64'sd2147483647, 64'sd2147483647, 64'sd2147483647,
                          64'sd2147483647, 64'sd2147483647, 64'sd2147483647), 1'b1);
        send_tri(make_tri(64'sd2147483647, -64'sd2147483648, 64'sd2147483647,
                          -64'sd2147483648, 64'sd2147483647, -64'sd2147483648,
                          64'sd2147483647, 64'sd2147483647, -64'sd2147483648), 1'b1);

        // Far triangle: t of 64000 units does not fit and saturates.
        wait_idle();
        write_ray(0, 0, 32'(-32000 * ONE), 0, 0, 32'd65536);
        send_tri(make_tri(-ONE, -ONE, 32000 * ONE, -ONE, 3 * ONE, 32000 * ONE,
                          3 * ONE, -ONE, 32000 * ONE), 1'b1);

        // Ray along -x, and a hit left open across a ray change.
        wait_idle();
        write_ray(32'(10 * ONE), 0, 0, -32'sd65536, 0, 0);
        send_tri(tri_on_ray(4), 1'b0);
        send_tri(tri_on_ray(7), 1'b0);
        wait_idle();
        write_ray(0, 0, 0, 0, 32'd65536, 0);
        send_tri(tri_on_ray(2), 1'b0);
        send_tri(last_tri, 1'b1);

        // Random phases: a new ray each time, then meshes. A mesh is sometimes
        // left open so that a ray change lands in the middle of one.
        sent = 0;
        while (sent < RANDOM_TRIS) begin
            wait_idle();
            random_ray();
            phase_end = sent + $urandom_range(25, 70);
            while (sent < phase_end) begin
                mesh_len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24)
                                                       : $urandom_range(1, 6);
                for (int k = 0; k < mesh_len; k++) begin
                    kind = $urandom_range(0, 9);
                    if (kind < 6)
                        tri_v = tri_on_ray($urandom_range(0, 1) ? $urandom_range(0, 8)
                                                                : $urandom_range(0, 3000));
                    else if (kind == 6 && k > 0)
                        tri_v = last_tri;
                    else
                        tri_v = noise_tri();
                    fin = (k == mesh_len - 1) && ($urandom_range(0, 7) != 0);
                    send_tri(tri_v, fin);
                    sent++;
                end
            end
        end
        send_tri(tri_on_ray(1), 1'b1);

        in_valid <= 1'b0;
        wait_idle();
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
